FILE: sv/wli_pkg.sv
// Shared types and constants of the waypoint line interpolator.
package wli_pkg;

    localparam logic [1:0] MODE_WRITE    = 2'd0;
    localparam logic [1:0] MODE_FOLLOW   = 2'd1;
    localparam logic [1:0] MODE_DIRECT   = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam logic CFG_SPEED = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    localparam int unsigned SQRT_STEPS = 34;
    localparam int unsigned DIV_STEPS  = 50;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         wp_index;
        logic signed [31:0] pt_x;
        logic signed [31:0] pt_y;
        logic signed [31:0] pt_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic [31:0]        now_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               pos_valid;
        logic               segment_done;
        logic               route_done;
        logic [3:0]         segment_number;
    } t_out_item;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_SQRT,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic        start;
        t_alu_op     op;
        logic [67:0] a;
        logic [32:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [65:0] res;
    } t_alu_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_DELTA,
        S_SQ_GO,
        S_SQ_WAIT,
        S_RT_GO,
        S_RT_WAIT,
        S_DUR_GO,
        S_DUR_WAIT,
        S_VEL_GO,
        S_VEL_WAIT,
        S_TICK,
        S_POS_GO,
        S_POS_WAIT,
        S_OUT
    } t_state;

endpackage

FILE: sv/wli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wli_ram #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/wli_alu.sv
// Shared arithmetic unit: registered multiply, bit-serial square root and division.
module wli_alu import wli_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);
    logic        r_busy;
    logic        r_done;
    t_alu_op     r_op;
    logic [5:0]  r_cnt;
    logic [67:0] r_acc;
    logic [35:0] r_rem;
    logic [31:0] r_div;
    logic [65:0] r_res;

    logic [37:0] sq_rem;
    logic [37:0] sq_trial;
    logic [37:0] sq_diff;
    logic        sq_ge;
    logic [32:0] dv_rem;
    logic [32:0] dv_diff;
    logic        dv_ge;

    always_comb begin
        sq_rem   = {r_rem, r_acc[67:66]};
        sq_trial = {2'b00, r_res[33:0], 2'b01};
        sq_ge    = sq_rem >= sq_trial;
        sq_diff  = sq_rem - sq_trial;
        dv_rem   = {r_rem[31:0], r_acc[49]};
        dv_ge    = dv_rem >= {1'b0, r_div};
        dv_diff  = dv_rem - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op  <= i_req.op;
                r_acc <= i_req.a;
                r_div <= i_req.b[31:0];
                r_rem <= '0;
                if (i_req.op == ALU_MUL) begin
                    r_res  <= 66'(i_req.a[32:0]) * 66'(i_req.b);
                    r_done <= 1'b1;
                end else begin
                    r_res  <= '0;
                    r_busy <= 1'b1;
                    r_cnt  <= (i_req.op == ALU_SQRT) ? 6'(SQRT_STEPS - 1) : 6'(DIV_STEPS - 1);
                end
            end else if (r_busy) begin
                unique case (r_op)
                    ALU_SQRT: begin
                        r_rem <= sq_ge ? sq_diff[35:0] : sq_rem[35:0];
                        r_res <= {r_res[64:0], sq_ge};
                        r_acc <= {r_acc[65:0], 2'b00};
                    end
                    ALU_DIV: begin
                        r_rem <= {4'b0, (dv_ge ? dv_diff[31:0] : dv_rem[31:0])};
                        r_res <= {r_res[64:0], dv_ge};
                        r_acc <= {r_acc[66:0], 1'b0};
                    end
                    default: begin
                        r_res <= r_res;
                    end
                endcase
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{done: r_done, res: r_res};
endmodule

FILE: sv/waypoint_line_interpolator_core.sv
// Top level: sequencer, waypoint table and shared arithmetic unit.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one tick or table
// write per transaction; output channel (o_out_valid / i_out_stall / o_out_data)
// gives exactly one result transaction per input transaction, in order.
// The config port (i_cfg_we, i_cfg_index, i_cfg_data) writes speed (index 0)
// and waypoint count (index 1); write only while idle.
// One transaction is processed at a time; o_in_stall is high while busy.
// A table write, reserved mode or route end goes straight to S_OUT. A tick
// of an active segment that does not end it runs three multiplies on the shared
// unit. A tick that starts a segment also has the shared unit run a 34-step
// square root and a 50-step duration division, then three 50-step velocity
// divisions for a nonzero duration; follow mode first does two table reads.
// A finished result waits in the output register while the receiver stalls;
// the next transaction is accepted once the result is loaded there.
// Synchronous active-low reset clears the sequencer, the active segment,
// the route position and the config registers (speed 1.0 m/s, count 0).
// The waypoint table is not cleared.
module waypoint_line_interpolator_core import wli_pkg::*; #(
    parameter int unsigned WAYPOINT_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int unsigned ADDR_W = $clog2(WAYPOINT_DEPTH);
    localparam int unsigned EXT_W  = (ADDR_W + 1 > 5) ? ADDR_W + 1 : 5;
    localparam logic [EXT_W-1:0] DEPTH_E = EXT_W'(WAYPOINT_DEPTH);

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -48'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    t_state             r_state, n_state;
    t_in_item           r_item, n_item;
    logic               r_active, n_active;
    logic [ADDR_W-1:0]  r_cs, n_cs;
    logic signed [31:0] r_sp [3];
    logic signed [31:0] n_sp [3];
    logic signed [31:0] r_e [3];
    logic signed [31:0] n_e [3];
    logic signed [32:0] r_d [3];
    logic signed [32:0] n_d [3];
    logic signed [31:0] r_v [3];
    logic signed [31:0] n_v [3];
    logic signed [31:0] r_pos [3];
    logic signed [31:0] n_pos [3];
    logic [31:0]        r_t0, n_t0;
    logic [31:0]        r_dur, n_dur;
    logic [67:0]        r_sum, n_sum;
    logic [33:0]        r_len, n_len;
    logic [1:0]         r_axis, n_axis;
    t_out_item          r_pend, n_pend;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_speed, n_speed;
    logic [4:0]         r_count, n_count;

    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [95:0]        ram_q;

    logic [EXT_W-1:0]   cs_e, cs_n1, cnt_e, idx_e;
    logic [31:0]        el, sp, dur_sat, qc, vel;
    logic [49:0]        quo;
    logic               vneg;
    logic [47:0]        prod;
    logic signed [47:0] psum;
    logic               accept;

    wli_ram #(.WIDTH(96), .DEPTH(WAYPOINT_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_in_data.pt_x, i_in_data.pt_y, i_in_data.pt_z}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    wli_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cs        <= '0;
            r_out_valid <= 1'b0;
            r_speed     <= 32'd65536;
            r_count     <= '0;
        end else begin
            r_active    <= n_active;
            r_cs        <= n_cs;
            r_out_valid <= n_out_valid;
            r_speed     <= n_speed;
            r_count     <= n_count;
        end
        r_item <= n_item;
        r_sp   <= n_sp;
        r_e    <= n_e;
        r_d    <= n_d;
        r_v    <= n_v;
        r_pos  <= n_pos;
        r_t0   <= n_t0;
        r_dur  <= n_dur;
        r_sum  <= n_sum;
        r_len  <= n_len;
        r_axis <= n_axis;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_active    = r_active;
        n_cs        = r_cs;
        n_sp        = r_sp;
        n_e         = r_e;
        n_d         = r_d;
        n_v         = r_v;
        n_pos       = r_pos;
        n_t0        = r_t0;
        n_dur       = r_dur;
        n_sum       = r_sum;
        n_len       = r_len;
        n_axis      = r_axis;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_speed     = r_speed;
        n_count     = r_count;
        alu_req     = '0;
        ram_we      = 1'b0;

        accept = i_in_valid && (r_state == S_IDLE);
        cs_e   = EXT_W'(r_cs);
        cs_n1  = cs_e + EXT_W'(1);
        cnt_e  = (EXT_W'(r_count) > DEPTH_E) ? DEPTH_E : EXT_W'(r_count);
        idx_e  = EXT_W'(i_in_data.wp_index);
        ram_waddr = idx_e[ADDR_W-1:0];
        ram_raddr = (r_state == S_RD1) ? cs_n1[ADDR_W-1:0] : r_cs;
        el     = r_item.now_time - r_t0;
        sp     = (r_speed == 32'd0) ? 32'd1 : r_speed;
        dur_sat = (|alu_rsp.res[49:32]) ? 32'hFFFFFFFF : alu_rsp.res[31:0];
        quo    = alu_rsp.res[49:0];
        qc     = (quo > 50'h80000000) ? 32'h80000000 : quo[31:0];
        vel    = r_d[r_axis][32] ? (32'd0 - qc)
               : ((qc == 32'h80000000) ? 32'h7FFFFFFF : qc);
        vneg   = r_v[r_axis][31];
        prod   = {1'b0, alu_rsp.res[62:16]};
        psum   = vneg ? (48'(r_sp[r_axis]) - $signed(prod))
                      : (48'(r_sp[r_axis]) + $signed(prod));

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPEED: n_speed = i_cfg_data;
                CFG_COUNT: n_count = i_cfg_data[4:0];
                default:   n_speed = r_speed;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item = i_in_data;
                    n_pend = '0;
                    n_pend.segment_number = cs_e[3:0];
                    unique case (i_in_data.mode)
                        MODE_WRITE: begin
                            ram_we   = idx_e < DEPTH_E;
                            n_cs     = '0;
                            n_active = 1'b0;
                            n_pend.segment_number = '0;
                            n_state  = S_OUT;
                        end
                        MODE_FOLLOW, MODE_DIRECT: begin
                            if (r_active) begin
                                n_state = S_TICK;
                            end else if (i_in_data.mode == MODE_DIRECT) begin
                                n_sp[0] = i_in_data.pt_x;
                                n_sp[1] = i_in_data.pt_y;
                                n_sp[2] = i_in_data.pt_z;
                                n_e[0]  = i_in_data.end_x;
                                n_e[1]  = i_in_data.end_y;
                                n_e[2]  = i_in_data.end_z;
                                n_t0    = i_in_data.now_time;
                                n_state = S_DELTA;
                            end else if (cs_n1 < cnt_e) begin
                                n_t0    = i_in_data.now_time;
                                n_state = S_RD0;
                            end else begin
                                n_pend.route_done = 1'b1;
                                n_state = S_OUT;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_RD0: begin
                n_state = S_RD1;
            end
            S_RD1: begin
                n_sp[0] = ram_q[95:64];
                n_sp[1] = ram_q[63:32];
                n_sp[2] = ram_q[31:0];
                n_state = S_RD2;
            end
            S_RD2: begin
                n_e[0]  = ram_q[95:64];
                n_e[1]  = ram_q[63:32];
                n_e[2]  = ram_q[31:0];
                n_state = S_DELTA;
            end
            S_DELTA: begin
                for (int k = 0; k < 3; k++) begin
                    n_d[k] = 33'(r_e[k]) - 33'(r_sp[k]);
                end
                n_sum   = '0;
                n_axis  = '0;
                n_state = S_SQ_GO;
            end
            S_SQ_GO: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_req.a     = 68'(mag33(r_d[r_axis]));
                alu_req.b     = mag33(r_d[r_axis]);
                n_state       = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (alu_rsp.done) begin
                    n_sum = r_sum + 68'(alu_rsp.res);
                    if (r_axis == 2'd2) begin
                        n_state = S_RT_GO;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = S_SQ_GO;
                    end
                end
            end
            S_RT_GO: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_SQRT;
                alu_req.a     = r_sum;
                n_state       = S_RT_WAIT;
            end
            S_RT_WAIT: begin
                if (alu_rsp.done) begin
                    n_len   = alu_rsp.res[33:0];
                    n_state = S_DUR_GO;
                end
            end
            S_DUR_GO: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_req.a     = {18'd0, r_len, 16'd0};
                alu_req.b     = {1'b0, sp};
                n_state       = S_DUR_WAIT;
            end
            S_DUR_WAIT: begin
                if (alu_rsp.done) begin
                    n_dur  = dur_sat;
                    n_axis = '0;
                    if (dur_sat == 32'd0) begin
                        for (int k = 0; k < 3; k++) begin
                            n_v[k] = '0;
                        end
                        n_active = 1'b1;
                        n_state  = S_TICK;
                    end else begin
                        n_state = S_VEL_GO;
                    end
                end
            end
            S_VEL_GO: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_req.a     = {19'd0, mag33(r_d[r_axis]), 16'd0};
                alu_req.b     = {1'b0, r_dur};
                n_state       = S_VEL_WAIT;
            end
            S_VEL_WAIT: begin
                if (alu_rsp.done) begin
                    n_v[r_axis] = vel;
                    if (r_axis == 2'd2) begin
                        n_active = 1'b1;
                        n_state  = S_TICK;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = S_VEL_GO;
                    end
                end
            end
            S_TICK: begin
                n_axis = '0;
                if (r_dur == 32'd0 || el > r_dur) begin
                    n_pend = '0;
                    n_pend.segment_done   = 1'b1;
                    n_pend.segment_number = cs_e[3:0];
                    n_active = 1'b0;
                    if (r_item.mode == MODE_FOLLOW && cs_n1 < DEPTH_E) begin
                        n_cs = cs_n1[ADDR_W-1:0];
                    end
                    n_state = S_OUT;
                end else begin
                    n_state = S_POS_GO;
                end
            end
            S_POS_GO: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_req.a     = 68'(mag33({r_v[r_axis][31], r_v[r_axis]}));
                alu_req.b     = {1'b0, el};
                n_state       = S_POS_WAIT;
            end
            S_POS_WAIT: begin
                if (alu_rsp.done) begin
                    n_pos[r_axis] = sat32(psum);
                    if (r_axis == 2'd2) begin
                        n_pend.pos_x          = n_pos[0];
                        n_pend.pos_y          = n_pos[1];
                        n_pend.pos_z          = n_pos[2];
                        n_pend.pos_valid      = 1'b1;
                        n_pend.segment_done   = 1'b0;
                        n_pend.route_done     = 1'b0;
                        n_pend.segment_number = cs_e[3:0];
                        n_state = S_OUT;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = S_POS_GO;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

FILE: sv/wli_checker.sv
// Port-level checker for the waypoint line interpolator, bound to the top level.
module wli_checker import wli_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result transaction changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted twice without processing");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pos_valid |->
            !o_out_data.segment_done && !o_out_data.route_done)
        else $error("setpoint given together with an end flag");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.pos_valid |->
            o_out_data.pos_x == 0 && o_out_data.pos_y == 0 && o_out_data.pos_z == 0)
        else $error("nonzero position without a setpoint");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");
endmodule

bind waypoint_line_interpolator_core wli_checker u_wli_checker (.*);

FILE: bench/testbench.sv
// Self-checking testbench for waypoint_line_interpolator_core: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
    import wli_pkg::*;

    localparam int DEPTH = 16;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 175;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item lit;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_SPEED;
    logic [31:0] i_cfg_data = '0;

    waypoint_line_interpolator_core #(.WAYPOINT_DEPTH(DEPTH)) DUT (.*);

    always #5 i_clk = ~i_clk;

    // setpoint predictor state
    longint      wp_x[DEPTH], wp_y[DEPTH], wp_z[DEPTH];
    bit          wp_written[DEPTH];
    bit          seg_live;
    int unsigned cur_seg;
    longint      start_x, start_y, start_z, vel_x, vel_y, vel_z;
    logic [31:0] start_t, seg_dur;
    logic [31:0] speed_reg;
    int unsigned count_reg;

    t_out_item   setpoint_q[$];
    int          errors = 0;
    longint      cycles = 0;
    bit          calm = 0;
    logic [31:0] clock_now = 0;
    t_row        rows[$];

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned magn(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic logic [33:0] floor_root(logic [67:0] v);
        logic [33:0] r;
        logic [33:0] t;
        r = '0;
        for (int i = 33; i >= 0; i--) begin
            t = r | (34'd1 << i);
            if ({34'd0, t} * {34'd0, t} <= v) r = t;
        end
        return r;
    endfunction

    function automatic longint axis_vel(longint d, logic [31:0] dur);
        longint unsigned q;
        if (dur == 0) return 0;
        q = (magn(d) << 16) / dur;
        if (q > 64'h80000000) q = 64'h80000000;
        return sat32(d < 0 ? -longint'(q) : longint'(q));
    endfunction

    function automatic longint axis_pos(longint s, longint v, logic [31:0] el);
        longint unsigned p;
        p = (magn(v) * longint'(el)) >> 16;
        return sat32(v < 0 ? s - longint'(p) : s + longint'(p));
    endfunction

    function automatic void open_segment(longint sx, longint sy, longint sz,
                                         longint ex, longint ey, longint ez,
                                         logic [31:0] now);
        longint dx, dy, dz;
        logic [67:0] sum;
        longint unsigned len, dur, sp;
        dx = ex - sx;
        dy = ey - sy;
        dz = ez - sz;
        sum = 68'(magn(dx)) * 68'(magn(dx)) + 68'(magn(dy)) * 68'(magn(dy))
            + 68'(magn(dz)) * 68'(magn(dz));
        len = 64'(floor_root(sum));
        sp = speed_reg == 0 ? 1 : speed_reg;
        dur = (len << 16) / sp;
        if (dur > 64'hFFFFFFFF) dur = 64'hFFFFFFFF;
        seg_dur = dur[31:0];
        start_x = sx;
        start_y = sy;
        start_z = sz;
        vel_x = axis_vel(dx, seg_dur);
        vel_y = axis_vel(dy, seg_dur);
        vel_z = axis_vel(dz, seg_dur);
        start_t = now;
        seg_live = 1;
    endfunction

    function automatic t_out_item next_setpoint(t_in_item it);
        t_out_item o;
        int unsigned cnt;
        logic [31:0] el;
        o = '0;
        cnt = count_reg > DEPTH ? DEPTH : count_reg;
        if (it.mode == MODE_WRITE) begin
            wp_x[it.wp_index] = it.pt_x;
            wp_y[it.wp_index] = it.pt_y;
            wp_z[it.wp_index] = it.pt_z;
            wp_written[it.wp_index] = 1;
            cur_seg = 0;
            seg_live = 0;
        end else if (it.mode == MODE_FOLLOW || it.mode == MODE_DIRECT) begin
            if (!seg_live) begin
                if (it.mode == MODE_DIRECT)
                    open_segment(it.pt_x, it.pt_y, it.pt_z, it.end_x, it.end_y, it.end_z,
                                 it.now_time);
                else if (cur_seg + 1 < cnt)
                    open_segment(wp_x[cur_seg], wp_y[cur_seg], wp_z[cur_seg],
                                 wp_x[cur_seg+1], wp_y[cur_seg+1], wp_z[cur_seg+1],
                                 it.now_time);
                else
                    o.route_done = 1;
            end
            if (seg_live) begin
                el = it.now_time - start_t;
                if (seg_dur == 0 || el > seg_dur) begin
                    o.segment_done = 1;
                    seg_live = 0;
                    o.segment_number = cur_seg[3:0];
                    if (it.mode == MODE_FOLLOW && cur_seg + 1 < DEPTH) cur_seg++;
                    return o;
                end
                o.pos_x = axis_pos(start_x, vel_x, el);
                o.pos_y = axis_pos(start_y, vel_y, el);
                o.pos_z = axis_pos(start_z, vel_z, el);
                o.pos_valid = 1;
            end
        end
        o.segment_number = cur_seg[3:0];
        return o;
    endfunction

    // a follow tick must never open a segment on an unwritten table entry
    function automatic bit reads_unwritten(t_in_item it);
        int unsigned cnt;
        cnt = count_reg > DEPTH ? DEPTH : count_reg;
        return it.mode == MODE_FOLLOW && !seg_live && cur_seg + 1 < cnt
            && (!wp_written[cur_seg] || !wp_written[cur_seg+1]);
    endfunction

    task automatic send(t_in_item it, bit typed = 0, t_out_item lit = '0);
        t_out_item e;
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 35) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        if (reads_unwritten(it)) begin
            it.mode = MODE_WRITE;
            it.wp_index = wp_written[cur_seg] ? 4'(cur_seg + 1) : 4'(cur_seg);
            typed = 0;
        end
        i_in_valid = 1'b1;
        i_in_data = it;
        do @(posedge i_clk); while (o_in_stall);
        e = next_setpoint(it);
        setpoint_q.push_back(typed ? lit : e);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain();
        while (setpoint_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_SPEED) speed_reg = val;
        else count_reg = val[4:0];
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return $urandom_range(0, 32'h200000) - 32'h100000;
    endfunction

    function automatic logic [31:0] advance_clock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) clock_now = $urandom;
        else if (r > 8) clock_now += $urandom_range(0, 32'h20000);
        return clock_now;
    endfunction

    function automatic t_in_item tick(logic [1:0] m);
        t_in_item it;
        it = '0;
        it.mode = m;
        it.pt_x = rand_coord();
        it.pt_y = rand_coord();
        it.pt_z = rand_coord();
        it.end_x = rand_coord();
        it.end_y = rand_coord();
        it.end_z = rand_coord();
        it.now_time = advance_clock();
        return it;
    endfunction

    function automatic t_in_item mk(logic [1:0] m, logic [3:0] idx, logic [31:0] sx,
                                    logic [31:0] sy, logic [31:0] sz, logic [31:0] ex,
                                    logic [31:0] ey, logic [31:0] ez, logic [31:0] now);
        return '{m, idx, sx, sy, sz, ex, ey, ez, now};
    endfunction

    always @(negedge i_clk)
        i_out_stall <= !calm && $urandom_range(0, 99) < 35;

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (setpoint_q.size() == 0) begin
                $error("unexpected result transaction %h", o_out_data);
                errors++;
            end else begin
                e = setpoint_q.pop_front();
                if (o_out_data.pos_x !== e.pos_x) begin
                    $error("pos_x expected %h actual %h", e.pos_x, o_out_data.pos_x);
                    errors++;
                end
                if (o_out_data.pos_y !== e.pos_y) begin
                    $error("pos_y expected %h actual %h", e.pos_y, o_out_data.pos_y);
                    errors++;
                end
                if (o_out_data.pos_z !== e.pos_z) begin
                    $error("pos_z expected %h actual %h", e.pos_z, o_out_data.pos_z);
                    errors++;
                end
                if (o_out_data.pos_valid !== e.pos_valid) begin
                    $error("pos_valid expected %b actual %b", e.pos_valid,
                           o_out_data.pos_valid);
                    errors++;
                end
                if (o_out_data.segment_done !== e.segment_done) begin
                    $error("segment_done expected %b actual %b", e.segment_done,
                           o_out_data.segment_done);
                    errors++;
                end
                if (o_out_data.route_done !== e.route_done) begin
                    $error("route_done expected %b actual %b", e.route_done,
                           o_out_data.route_done);
                    errors++;
                end
                if (o_out_data.segment_number !== e.segment_number) begin
                    $error("segment_number expected %0d actual %0d", e.segment_number,
                           o_out_data.segment_number);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** waypoint_line_interpolator_core: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [31:0] speeds[PHASES] = '{32'd65536, 32'd0, 32'd1, 32'hFFFFFFFF,
                                        32'd196608, 32'd65536, 32'd32768, 32'd131072};
        logic [31:0] counts[PHASES] = '{32'd2, 32'd16, 32'd31, 32'd0,
                                        32'd17, 32'd1, 32'd5, 32'd16};
        t_in_item it;
        int r;
        int n;
        seg_live = 0;
        cur_seg = 0;
        seg_dur = 0;
        start_t = 0;
        speed_reg = 32'd65536;
        count_reg = 0;
        foreach (wp_written[i]) wp_written[i] = 0;

        rows.push_back('{mk(MODE_FOLLOW, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 0, 0, 1, 0}});
        rows.push_back('{mk(MODE_RESERVED, 0, 0, 0, 0, 0, 0, 0, 0), 1, '0});
        rows.push_back('{mk(MODE_WRITE, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF), 1, '0});
        rows.push_back('{mk(MODE_WRITE, 15, 32'h80000000, 32'h80000000, 32'h80000000,
                            32'h80000000, 32'h80000000, 32'h80000000, 0), 1, '0});
        rows.push_back('{mk(MODE_DIRECT, 0, 5, 5, 5, 5, 5, 5, 7), 1, '{0, 0, 0, 0, 1, 0, 0}});
        rows.push_back('{mk(MODE_DIRECT, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0), 0, '0});
        rows.push_back('{mk(MODE_DIRECT, 3, 1, 2, 3, 4, 5, 6, 32'h10000), 0, '0});
        rows.push_back('{mk(MODE_FOLLOW, 0, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF), 0, '0});
        rows.push_back('{mk(MODE_RESERVED, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk(MODE_WRITE, 1, 32'h30000, 32'h40000, 0, 0, 0, 0, 0), 1, '0});
        rows.push_back('{mk(MODE_DIRECT, 0, 0, 0, 0, 32'h30000, 32'h40000, 0, 1000), 0, '0});
        rows.push_back('{mk(MODE_FOLLOW, 0, 0, 0, 0, 0, 0, 0, 1000 + 32'h28000), 0, '0});
        rows.push_back('{mk(MODE_DIRECT, 0, 0, 0, 0, 0, 0, 0, 1000 + 32'h60000), 0, '0});
        rows.push_back('{mk(MODE_DIRECT, 0, 32'h50000, 0, 32'h20000, 32'hFFFD0000,
                            32'hFFFF0000, 0, 32'hFFFF0000), 0, '0});
        rows.push_back('{mk(MODE_DIRECT, 0, 0, 0, 0, 0, 0, 0, 32'h10000), 0, '0});
        rows.push_back('{mk(MODE_DIRECT, 0, 0, 0, 0, 0, 0, 0, 32'h90000), 0, '0});

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].lit);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            calm = (ph == 5);
            write_reg(CFG_SPEED, ph == 6 ? $urandom : speeds[ph]);
            write_reg(CFG_COUNT, ph == 6 ? $urandom_range(0, 31) : counts[ph]);
            n = 0;
            while (n < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    for (int k = $urandom_range(2, DEPTH) - 1, j = 0; j <= k; j++) begin
                        it = tick(MODE_WRITE);
                        it.wp_index = 4'(j);
                        send(it);
                        n++;
                    end
                end else begin
                    if (r < 60) it = tick(MODE_FOLLOW);
                    else if (r < 85) it = tick(MODE_DIRECT);
                    else if (r < 89) it = tick(MODE_RESERVED);
                    else begin
                        it = t_in_item'({6'd0, $urandom, $urandom, $urandom, $urandom,
                                         $urandom, $urandom, $urandom});
                        it.mode = 2'($urandom_range(0, 3));
                        it.wp_index = 4'($urandom);
                        clock_now = it.now_time;
                    end
                    send(it);
                    n++;
                end
            end
            drain();
        end

        if (errors == 0 && setpoint_q.size() == 0)
            $display("** waypoint_line_interpolator_core: PASSED **");
        else
            $display("** waypoint_line_interpolator_core: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
sv/wli_pkg.sv
sv/wli_ram.sv
sv/wli_alu.sv
sv/waypoint_line_interpolator_core.sv
sv/wli_checker.sv
bench/testbench.sv
